// ----- sv/deup_pkg.sv -----
// Shared constants for the automaton edge usage profiler: field widths, action codes, defaults.
package deup_pkg;

  // Parameter defaults
  localparam int STATE_COUNT_DEF    = 64;
  localparam int ALPHABET_SIZE_DEF  = 16;
  localparam int COUNT_WIDTH_DEF    = 32;
  localparam int WORD_TAG_WIDTH_DEF = 16;

  // Fixed field widths of the stream and configuration ports
  localparam int ACTION_W      = 3;
  localparam int FIELD_STATE_W = 6;
  localparam int FIELD_SYM_W   = 4;
  localparam int OUT_COUNT_W   = 32;
  localparam int S_TDATA_W     = 24;
  localparam int S_TUSER_W     = 3;
  localparam int M_TDATA_W     = 104;
  localparam int OUT_PAD_W     = M_TDATA_W - 2 - 3 * OUT_COUNT_W;

  // Action codes carried on s_axis_tuser
  localparam logic [ACTION_W-1:0] ACT_LOAD   = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_SYMBOL = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_END    = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_READ   = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 3'd4;

endpackage

// ----- sv/deup_ram.sv -----
// Generic simple dual-port RAM with one write port and one registered read port.
module deup_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- sv/dfa_edge_usage_profiler_top.sv -----
// Top level of the automaton edge usage profiler: walk control, statistics update, result register.
//
// The block walks a loaded automaton over words fed one symbol per beat and
// keeps, per edge (state, symbol), the number of words that used it, its total
// uses and the most uses within one word; all counts saturate. Edge tables live
// in one RAM ({next state, edge valid, reference valid}) and the statistics in a
// second RAM ({word tag, count in current word, max, total, words}), both with
// a registered read. Every input beat has an accept cycle and an execution
// cycle: the accept cycle presents the edge address to both RAMs, the
// execution cycle gets the data back, updates and writes the entry and the walk
// state; the next symbol's address depends on the next state just read, so a
// new beat is taken only once the last one is done. A read beat whose result
// finds the output register still full holds in execution until the register
// drains. After reset both RAMs go through a clearing pass over all
// STATE_COUNT*ALPHABET_SIZE entries (1024 at default size) before the first
// beat is taken; a clear beat sweeps the statistics RAM the same way. When the
// word number wraps, all word tags are wiped by a read-modify-write pass over
// every entry. No beat is accepted during a pass; configuration writes are
// taken at any time but are meant only while the block is idle.
module dfa_edge_usage_profiler_top
  import deup_pkg::*;
#(
  parameter int STATE_COUNT    = STATE_COUNT_DEF,
  parameter int ALPHABET_SIZE  = ALPHABET_SIZE_DEF,
  parameter int COUNT_WIDTH    = COUNT_WIDTH_DEF,
  parameter int WORD_TAG_WIDTH = WORD_TAG_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  // Input beats
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // [5:0] state_index, [9:6] symbol, [15:10] next_state, [16] edge_valid,
  // [17] reference_valid, [23:18] zero
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  // [2:0] action
  input  logic [S_TUSER_W-1:0] s_axis_tuser,
  // Result beats
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // [0] edge_present, [1] missing_in_reference, [33:2] words_using,
  // [65:34] total_uses, [97:66] max_in_one_word, [103:98] zero
  output logic [M_TDATA_W-1:0] m_axis_tdata,
  // Entry state register
  input  logic                 cfg_wr_en,
  input  logic [FIELD_STATE_W-1:0] cfg_wr_data
);

  localparam int STATE_W    = $clog2(STATE_COUNT);
  localparam int EDGE_COUNT = STATE_COUNT * ALPHABET_SIZE;
  localparam int EDGE_W     = $clog2(EDGE_COUNT);
  localparam int CW         = COUNT_WIDTH;
  localparam int TW         = WORD_TAG_WIDTH;
  localparam int TBL_W      = STATE_W + 2;
  localparam int STAT_W     = TW + 4 * CW;
  localparam int MOD_DEPTH  = 2 ** FIELD_STATE_W;

  // Controller states
  localparam logic [2:0] ST_INIT    = 3'd0;
  localparam logic [2:0] ST_IDLE    = 3'd1;
  localparam logic [2:0] ST_EXEC    = 3'd2;
  localparam logic [2:0] ST_CLEAR   = 3'd3;
  localparam logic [2:0] ST_WIPE_RD = 3'd4;
  localparam logic [2:0] ST_WIPE_WR = 3'd5;

  logic [2:0]               state;
  logic [EDGE_W-1:0]        sweep;
  logic [FIELD_STATE_W-1:0] entry_state;
  logic [STATE_W-1:0]       current_state;
  logic                     at_word_start;
  logic                     word_dead;
  logic [TW-1:0]            word_number;

  // Beat captured at accept
  logic [ACTION_W-1:0] it_act;
  logic [EDGE_W-1:0]   it_addr;
  logic                it_ok;
  logic [STATE_W-1:0]  it_next;
  logic                it_ev;
  logic                it_rv;
  logic [STATE_W-1:0]  it_st;

  logic                 m_valid;
  logic [M_TDATA_W-1:0] m_data;

  // ---------------------------------------------------------------------------
  // State values reduced modulo STATE_COUNT through a constant lookup
  // ---------------------------------------------------------------------------
  logic [STATE_W-1:0] state_mod [MOD_DEPTH];

  for (genvar g = 0; g < MOD_DEPTH; g++) begin : g_mod
    assign state_mod[g] = STATE_W'(g % STATE_COUNT);
  end

  // ---------------------------------------------------------------------------
  // Input decode
  // ---------------------------------------------------------------------------
  logic [ACTION_W-1:0]      in_action;
  logic [FIELD_STATE_W-1:0] in_state;
  logic [FIELD_SYM_W-1:0]   in_symbol;
  logic [FIELD_STATE_W-1:0] in_next;
  logic                     in_ev;
  logic                     in_rv;
  logic                     s_accept;
  logic                     sym_ok;
  logic                     st_ok;
  logic                     in_ok;
  logic [STATE_W-1:0]       st_eff;
  logic [STATE_W-1:0]       src_state;
  logic [EDGE_W-1:0]        in_addr;

  assign in_action = s_axis_tuser[ACTION_W-1:0];
  assign in_state  = s_axis_tdata[5:0];
  assign in_symbol = s_axis_tdata[9:6];
  assign in_next   = s_axis_tdata[15:10];
  assign in_ev     = s_axis_tdata[16];
  assign in_rv     = s_axis_tdata[17];

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign sym_ok    = 32'(in_symbol) < 32'(ALPHABET_SIZE);
  assign st_ok     = 32'(in_state) < 32'(STATE_COUNT);
  // A word begins at the entry state; the walk state is always in range.
  assign st_eff    = at_word_start ? state_mod[entry_state] : current_state;
  assign src_state = (in_action == ACT_SYMBOL) ? st_eff : STATE_W'(in_state);
  assign in_ok     = (in_action == ACT_SYMBOL) ? sym_ok : (sym_ok && st_ok);
  assign in_addr   = EDGE_W'(src_state) * EDGE_W'(ALPHABET_SIZE) + EDGE_W'(in_symbol);

  // ---------------------------------------------------------------------------
  // Edge table RAM: {next state, edge valid, reference valid}
  // ---------------------------------------------------------------------------
  logic              tbl_wr_en;
  logic [EDGE_W-1:0] tbl_wr_addr;
  logic [TBL_W-1:0]  tbl_wr_data;
  logic [TBL_W-1:0]  tbl_rd_data;
  logic [STATE_W-1:0] rd_next;
  logic              rd_ev;
  logic              rd_rv;

  assign tbl_wr_en   = (state == ST_INIT) ||
                       ((state == ST_EXEC) && (it_act == ACT_LOAD) && it_ok);
  assign tbl_wr_addr = (state == ST_INIT) ? sweep : it_addr;
  assign tbl_wr_data = (state == ST_INIT) ? '0 : {it_next, it_ev, it_rv};
  assign {rd_next, rd_ev, rd_rv} = tbl_rd_data;

  deup_ram #(
    .WIDTH (TBL_W),
    .DEPTH (EDGE_COUNT)
  ) u_tbl_ram (
    .clk     (clk),
    .wr_en   (tbl_wr_en),
    .wr_addr (tbl_wr_addr),
    .wr_data (tbl_wr_data),
    .rd_en   (s_accept),
    .rd_addr (in_addr),
    .rd_data (tbl_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Statistics RAM: {tag, count in current word, max, total, words}
  // ---------------------------------------------------------------------------
  logic              st_wr_en;
  logic [EDGE_W-1:0] st_wr_addr;
  logic [STAT_W-1:0] st_wr_data;
  logic              st_rd_en;
  logic [EDGE_W-1:0] st_rd_addr;
  logic [STAT_W-1:0] st_rd_data;

  logic [TW-1:0] rd_tag;
  logic [CW-1:0] rd_cur;
  logic [CW-1:0] rd_max;
  logic [CW-1:0] rd_total;
  logic [CW-1:0] rd_words;

  assign {rd_tag, rd_cur, rd_max, rd_total, rd_words} = st_rd_data;

  // Symbol update: a fresh tag restarts the per-word count and counts the word.
  logic          sym_upd;
  logic          tag_hit;
  logic [CW-1:0] cur_base;
  logic [CW-1:0] cur_new;
  logic [CW-1:0] max_new;
  logic [CW-1:0] total_new;
  logic [CW-1:0] words_new;

  assign sym_upd   = (state == ST_EXEC) && (it_act == ACT_SYMBOL) && !word_dead &&
                     it_ok && rd_ev;
  assign tag_hit   = (rd_tag == word_number);
  assign cur_base  = tag_hit ? rd_cur : '0;
  assign cur_new   = (cur_base == {CW{1'b1}}) ? cur_base : cur_base + CW'(1);
  assign max_new   = (cur_new > rd_max) ? cur_new : rd_max;
  assign total_new = (rd_total == {CW{1'b1}}) ? rd_total : rd_total + CW'(1);
  assign words_new = (tag_hit || (rd_words == {CW{1'b1}})) ? rd_words :
                     rd_words + CW'(1);

  assign st_wr_en   = (state == ST_INIT) || (state == ST_CLEAR) ||
                      (state == ST_WIPE_WR) || sym_upd;
  assign st_wr_addr = (state == ST_EXEC) ? it_addr : sweep;
  assign st_rd_en   = s_accept || (state == ST_WIPE_RD);
  assign st_rd_addr = (state == ST_WIPE_RD) ? sweep : in_addr;

  always_comb begin
    case (state)
      ST_EXEC:    st_wr_data = {word_number, cur_new, max_new, total_new, words_new};
      ST_WIPE_WR: st_wr_data = {{TW{1'b0}}, rd_cur, rd_max, rd_total, rd_words};
      default:    st_wr_data = '0;
    endcase
  end

  deup_ram #(
    .WIDTH (STAT_W),
    .DEPTH (EDGE_COUNT)
  ) u_stat_ram (
    .clk     (clk),
    .wr_en   (st_wr_en),
    .wr_addr (st_wr_addr),
    .wr_data (st_wr_data),
    .rd_en   (st_rd_en),
    .rd_addr (st_rd_addr),
    .rd_data (st_rd_data)
  );

  // ---------------------------------------------------------------------------
  // Control
  // ---------------------------------------------------------------------------
  logic              sweep_last;
  logic              read_blocked;
  logic              read_fire;
  logic [TW-1:0]     word_inc;
  logic [M_TDATA_W-1:0] read_beat;

  assign sweep_last   = (sweep == EDGE_W'(EDGE_COUNT - 1));
  // Hold a read beat while the result register is full and not being taken.
  assign read_blocked = m_valid && !m_axis_tready;
  assign read_fire    = (state == ST_EXEC) && (it_act == ACT_READ) && !read_blocked;
  assign word_inc     = word_number + TW'(1);

  assign read_beat = {
    {OUT_PAD_W{1'b0}},
    it_ok ? OUT_COUNT_W'(rd_max)   : {OUT_COUNT_W{1'b0}},
    it_ok ? OUT_COUNT_W'(rd_total) : {OUT_COUNT_W{1'b0}},
    it_ok ? OUT_COUNT_W'(rd_words) : {OUT_COUNT_W{1'b0}},
    it_ok && rd_ev && !rd_rv,
    it_ok && rd_ev
  };

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_INIT;
      sweep         <= '0;
      entry_state   <= '0;
      current_state <= '0;
      at_word_start <= 1'b1;
      word_dead     <= 1'b0;
      word_number   <= TW'(1);
      m_valid       <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        entry_state <= cfg_wr_data;
      end

      if (read_fire) begin
        m_valid <= 1'b1;
      end else if (m_valid && m_axis_tready) begin
        m_valid <= 1'b0;
      end

      case (state)
        ST_INIT, ST_CLEAR: begin
          if (sweep_last) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + EDGE_W'(1);
          end
        end

        ST_IDLE: begin
          if (s_accept) begin
            state <= ST_EXEC;
          end
        end

        ST_EXEC: begin
          case (it_act)
            ACT_SYMBOL: begin
              state <= ST_IDLE;
              if (!word_dead) begin
                at_word_start <= 1'b0;
                if (it_ok && rd_ev) begin
                  current_state <= rd_next;
                end else begin
                  // Invalid edge: drop the rest of the word.
                  current_state <= it_st;
                  word_dead     <= 1'b1;
                end
              end
            end
            ACT_END: begin
              at_word_start <= 1'b1;
              word_dead     <= 1'b0;
              if (word_inc == '0) begin
                // Tag zero means unused: restart at one and wipe all tags.
                word_number <= TW'(1);
                sweep       <= '0;
                state       <= ST_WIPE_RD;
              end else begin
                word_number <= word_inc;
                state       <= ST_IDLE;
              end
            end
            ACT_READ: begin
              // Hold here until the result register can take the beat.
              if (!read_blocked) begin
                state <= ST_IDLE;
              end
            end
            ACT_CLEAR: begin
              sweep <= '0;
              state <= ST_CLEAR;
            end
            default: begin
              state <= ST_IDLE;
            end
          endcase
        end

        ST_WIPE_RD: begin
          state <= ST_WIPE_WR;
        end

        ST_WIPE_WR: begin
          if (sweep_last) begin
            sweep <= '0;
            state <= ST_IDLE;
          end else begin
            sweep <= sweep + EDGE_W'(1);
            state <= ST_WIPE_RD;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Beat capture and result payload
  always_ff @(posedge clk) begin
    if (s_accept) begin
      it_act  <= in_action;
      it_addr <= in_addr;
      it_ok   <= in_ok;
      it_next <= state_mod[in_next];
      it_ev   <= in_ev;
      it_rv   <= in_rv;
      it_st   <= st_eff;
    end
    if (read_fire) begin
      m_data <= read_beat;
    end
  end

  assign m_axis_tvalid = m_valid;
  assign m_axis_tdata  = m_data;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_word_number_nonzero: assert property (@(posedge clk) disable iff (rst)
    word_number != '0)
    else $error("word number reached the unused tag value");

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> (state == ST_EXEC))
    else $error("accepted beat did not enter execution");

  a_dead_word_holds: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EXEC) && (it_act == ACT_SYMBOL) && word_dead) |=>
      ($stable(current_state) && word_dead))
    else $error("symbol of a dead word changed the walk");

  a_no_stat_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !st_wr_en && !tbl_wr_en)
    else $error("RAM write while idle");

  a_wipe_restarts_tag: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_EXEC) && (it_act == ACT_END) && (word_inc == '0)) |=>
      ((state == ST_WIPE_RD) && (word_number == TW'(1))))
    else $error("word number wrap did not start a tag wipe");

endmodule
